### hdl/mqps_pkg.sv
// types, phase codes and tag codes shared by the mqtt packet stream parser
`default_nettype none
package mqps_pkg;

	localparam int LEN_W   = 28;
	localparam int HALF_W  = 16;

	// parse phases
	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_LENGTH  = 4'd1;
	localparam logic [3:0] PH_OTHER   = 4'd2;
	localparam logic [3:0] PH_TL_HI   = 4'd3;
	localparam logic [3:0] PH_TL_LO   = 4'd4;
	localparam logic [3:0] PH_TOPIC   = 4'd5;
	localparam logic [3:0] PH_PID_HI  = 4'd6;
	localparam logic [3:0] PH_PID_LO  = 4'd7;
	localparam logic [3:0] PH_PAYLOAD = 4'd8;
	localparam logic [3:0] PH_SKIP    = 4'd9;

	// byte roles
	localparam logic [2:0] ROLE_TYPE    = 3'd0;
	localparam logic [2:0] ROLE_LENGTH  = 3'd1;
	localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
	localparam logic [2:0] ROLE_TOPIC   = 3'd3;
	localparam logic [2:0] ROLE_PKT_ID  = 3'd4;
	localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
	localparam logic [2:0] ROLE_OTHER   = 3'd6;
	localparam logic [2:0] ROLE_SKIPPED = 3'd7;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_MALFORMED  = 3'd1;
	localparam logic [2:0] ERR_TOO_SHORT  = 3'd2;
	localparam logic [2:0] ERR_TOPIC_OVF  = 3'd3;
	localparam logic [2:0] ERR_NO_PKT_ID  = 3'd4;

	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	typedef struct packed {
		logic [3:0]        phase;
		logic [1:0]        len_cnt;
		logic [LEN_W-1:0]  len_acc;
		logic [LEN_W-1:0]  body_left;
		logic [3:0]        ptype;
		logic [3:0]        flags;
		logic [HALF_W-1:0] topic_len;
		logic [HALF_W-1:0] topic_left;
		logic [HALF_W-1:0] pkt_id;
		logic [2:0]        err;
	} state_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic [2:0]        byte_role;
		logic [3:0]        packet_type;
		logic [3:0]        header_flags;
		logic [LEN_W-1:0]  remaining_length;
		logic [HALF_W-1:0] topic_length;
		logic [HALF_W-1:0] packet_id;
		logic [2:0]        error_code;
		logic              end_of_packet;
	} result_t;

endpackage
`default_nettype wire

### hdl/mqps_rx_if.sv
// received byte channel
`default_nettype none
interface mqps_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### hdl/mqps_result_if.sv
// tagged byte result channel
`default_nettype none
interface mqps_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [2:0]  byte_role;
	logic [3:0]  packet_type;
	logic [3:0]  header_flags;
	logic [27:0] remaining_length;
	logic [15:0] topic_length;
	logic [15:0] packet_id;
	logic [2:0]  error_code;
	logic        end_of_packet;

	modport source (output valid, output data_byte, output byte_role, output packet_type,
		output header_flags, output remaining_length, output topic_length,
		output packet_id, output error_code, output end_of_packet, input ready);
	modport sink (input valid, input data_byte, input byte_role, input packet_type,
		input header_flags, input remaining_length, input topic_length,
		input packet_id, input error_code, input end_of_packet, output ready);
endinterface
`default_nettype wire

### hdl/mqps_step.sv
// next-state and byte tag logic for one received byte
`default_nettype none
module mqps_step
	import mqps_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  wire state_t     cur,
	input  wire logic [7:0] rx_byte,
	output state_t          nxt,
	output result_t         res
);

	logic [3:0]       ph;
	logic [2:0]       role;
	logic             eop;
	logic [LEN_W-1:0] shifted;
	logic [LEN_W-1:0] acc;
	logic [LEN_W-1:0] body;
	logic [15:0]      tl;
	logic [15:0]      tleft;
	logic             qos_nz;
	logic [3:0]       after_topic;
	logic             last_len;

	assign qos_nz      = cur.flags[2:1] != 2'b00;
	assign after_topic = qos_nz ? PH_PID_HI : PH_PAYLOAD;
	assign last_len    = ({1'b0, cur.len_cnt} + 3'd1) >= 3'(MAX_LENGTH_BYTES);
	assign acc         = cur.len_acc | shifted;
	assign body        = cur.body_left - LEN_W'(1);
	assign tl          = cur.topic_len | {8'h00, rx_byte};
	assign tleft       = cur.topic_left - 16'd1;

	always_comb begin
		unique case (cur.len_cnt)
			2'd0: shifted = LEN_W'(rx_byte[6:0]);
			2'd1: shifted = LEN_W'(rx_byte[6:0]) << 7;
			2'd2: shifted = LEN_W'(rx_byte[6:0]) << 14;
			default: shifted = LEN_W'(rx_byte[6:0]) << 21;
		endcase
	end

	always_comb begin
		nxt  = cur;
		role = ROLE_TYPE;
		eop  = 1'b0;
		ph   = cur.phase;
		if (ph > PH_SKIP || (ph >= PH_OTHER && cur.body_left == '0)) begin
			ph = PH_HEADER;
		end
		if (ph == PH_HEADER) begin
			role           = ROLE_TYPE;
			nxt.ptype      = rx_byte[7:4];
			nxt.flags      = rx_byte[3:0];
			nxt.len_cnt    = '0;
			nxt.len_acc    = '0;
			nxt.body_left  = '0;
			nxt.topic_len  = '0;
			nxt.topic_left = '0;
			nxt.pkt_id     = '0;
			nxt.err        = ERR_NONE;
			ph             = PH_LENGTH;
		end else if (ph == PH_LENGTH) begin
			role        = ROLE_LENGTH;
			nxt.len_acc = acc;
			if (rx_byte[7]) begin
				if (last_len) begin
					nxt.err = ERR_MALFORMED;
					eop     = 1'b1;
					ph      = PH_HEADER;
				end else begin
					nxt.len_cnt = cur.len_cnt + 2'd1;
				end
			end else begin
				nxt.body_left = acc;
				if (cur.ptype == TYPE_PUBLISH) begin
					if (acc < LEN_W'(2)) begin
						nxt.err = ERR_TOO_SHORT;
						ph      = PH_SKIP;
					end else begin
						ph = PH_TL_HI;
					end
				end else begin
					ph = PH_OTHER;
				end
				if (acc == '0) begin
					eop = 1'b1;
					ph  = PH_HEADER;
				end
			end
		end else begin
			nxt.body_left = body;
			unique case (ph)
				PH_OTHER: role = ROLE_OTHER;
				PH_TL_HI: begin
					role          = ROLE_TOPIC_LEN;
					nxt.topic_len = {rx_byte, 8'h00};
					ph            = PH_TL_LO;
				end
				PH_TL_LO: begin
					role           = ROLE_TOPIC_LEN;
					nxt.topic_len  = tl;
					nxt.topic_left = tl;
					if (LEN_W'(tl) + LEN_W'(2) > cur.len_acc) begin
						nxt.err = ERR_TOPIC_OVF;
						ph      = PH_SKIP;
					end else if (qos_nz && (LEN_W'(tl) + LEN_W'(4) > cur.len_acc)) begin
						nxt.err = ERR_NO_PKT_ID;
						ph      = PH_SKIP;
					end else if (tl != '0) begin
						ph = PH_TOPIC;
					end else begin
						ph = after_topic;
					end
				end
				PH_TOPIC: begin
					role           = ROLE_TOPIC;
					nxt.topic_left = tleft;
					if (tleft == '0) begin
						ph = after_topic;
					end
				end
				PH_PID_HI: begin
					role       = ROLE_PKT_ID;
					nxt.pkt_id = {rx_byte, 8'h00};
					ph         = PH_PID_LO;
				end
				PH_PID_LO: begin
					role       = ROLE_PKT_ID;
					nxt.pkt_id = cur.pkt_id | {8'h00, rx_byte};
					ph         = PH_PAYLOAD;
				end
				PH_PAYLOAD: role = ROLE_PAYLOAD;
				default: role = ROLE_SKIPPED;
			endcase
			if (body == '0) begin
				eop = 1'b1;
				ph  = PH_HEADER;
			end
		end
		nxt.phase = ph;
	end

	always_comb begin
		res.data_byte        = rx_byte;
		res.byte_role        = role;
		res.packet_type      = nxt.ptype;
		res.header_flags     = nxt.flags;
		res.remaining_length = nxt.len_acc;
		res.topic_length     = nxt.topic_len;
		res.packet_id        = nxt.pkt_id;
		res.error_code       = nxt.err;
		res.end_of_packet    = eop;
	end

endmodule
`default_nettype wire

### hdl/mqtt_packet_stream_parser_core.sv
// mqtt packet stream parser top level: input register, parse step, result register
//
//  channel  dir  payload                                   handshake
//  rx       in   rx_byte                                   valid/ready
//  result   out  data_byte, byte_role, packet_type, ...    valid/ready
//
// one byte per cycle while no result stalls; a byte goes from its transaction into
// the input register, then through the parse step into the result register
// arst_n clears the parse state and both valid flags
// a stalled result holds the pipe; rx stays ready while the input register is empty
// or can move on in the same cycle
`default_nettype none
module mqtt_packet_stream_parser_core
	import mqps_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mqps_rx_if.sink       rx,
	mqps_result_if.source result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    res_q;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic       adv;

	assign adv      = valid_s1 && (!out_valid_q || result.ready);
	assign rx.ready = !valid_s1 || adv;

	mqps_step #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_step (
		.cur    (state_q),
		.rx_byte(byte_s1),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.data_byte        = res_q.data_byte;
	assign result.byte_role        = res_q.byte_role;
	assign result.packet_type      = res_q.packet_type;
	assign result.header_flags     = res_q.header_flags;
	assign result.remaining_length = res_q.remaining_length;
	assign result.topic_length     = res_q.topic_length;
	assign result.packet_id        = res_q.packet_id;
	assign result.error_code       = res_q.error_code;
	assign result.end_of_packet    = res_q.end_of_packet;

endmodule
`default_nettype wire
